// ===== rtl/core/lms_pkg.sv =====
// ----------------------------------------------------------------------------
// LED marquee scroller package
// Sizes, request codes, scroll modes and the glyph table of the scroller.
// ----------------------------------------------------------------------------
package lms_pkg;

    localparam int COLUMNS     = 64;
    localparam int BASE_PERIOD = 6000;
    localparam int SPEED_MAX   = 100;
    localparam int SPEED_STEP  = 50;
    localparam int SPEED_RESET = 50;

    localparam int ADDR_W  = $clog2(COLUMNS);
    localparam int SUM_W   = (ADDR_W + 1 > 7) ? ADDR_W + 1 : 7;
    localparam int DELAY_W = 13;
    localparam int SPEED_W = 7;

    localparam int IDX_W   = 6;
    localparam int REQ_W   = 3;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 16;

    localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INIT  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_HORIZ = 3'd2;
    localparam logic [REQ_W-1:0] REQ_VERT  = 3'd3;

    typedef enum logic [1:0] {
        MODE_STOP  = 2'd0,
        MODE_HORIZ = 2'd1,
        MODE_VERT  = 2'd2
    } mode_t;

    localparam logic [7:0] GLYPH_ROM [64] = '{
        8'h00, 8'h44, 8'h6C, 8'h38, 8'h38, 8'h6C, 8'h44, 8'h00,
        8'h00, 8'h58, 8'h5C, 8'h54, 8'h54, 8'h74, 8'h34, 8'h00,
        8'h00, 8'h7E, 8'h7E, 8'h18, 8'h3C, 8'h46, 8'h40, 8'h00,
        8'h00, 8'h38, 8'h7C, 8'h40, 8'h40, 8'h7C, 8'h38, 8'h00,
        8'h00, 8'h08, 8'h7E, 8'h7E, 8'h44, 8'h4C, 8'h20, 8'h00,
        8'h00, 8'h38, 8'h7C, 8'h44, 8'h44, 8'h7C, 8'h38, 8'h00,
        8'h00, 8'h3C, 8'h3E, 8'h52, 8'h4A, 8'h7E, 8'h7C, 8'h00,
        8'h00, 8'h3C, 8'h3E, 8'h52, 8'h4A, 8'h7E, 8'h7C, 8'h00
    };

    // glyph entry for a physical column, column mod 64
    function automatic logic [7:0] glyph_at(input logic [ADDR_W-1:0] p);
        logic [5:0] g;
        g = 6'(p);
        return GLYPH_ROM[g];
    endfunction

    // physical address of a logical column: (idx mod COLUMNS + base) mod COLUMNS
    function automatic logic [ADDR_W-1:0] phys_addr(input logic [IDX_W-1:0] idx,
                                                    input logic [ADDR_W-1:0] base);
        logic [SUM_W-1:0] v;
        v = SUM_W'(idx);
        for (int k = 0; k < 8; k++)
        begin
            if (v >= SUM_W'(COLUMNS))
            begin
                v = v - SUM_W'(COLUMNS);
            end
        end
        v = v + SUM_W'(base);
        if (v >= SUM_W'(COLUMNS))
        begin
            v = v - SUM_W'(COLUMNS);
        end
        return v[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/core/led_marquee_scroller.sv =====
// ----------------------------------------------------------------------------
// LED marquee scroller
// Scrolling frame buffer of COLUMNS columns by 8 rows with a carry per column.
// ----------------------------------------------------------------------------
// One request is taken at a time and answered with one result transfer. A tick,
// read, init or horizontal start goes through ST_READ and ST_WAIT to the result:
// horizontal scrolling only advances a base pointer and init clears the
// per-entry valid bits, so neither touches the column memory. A vertical step,
// from a start request or from a tick that ends the period, sweeps the whole
// column memory read-modify-write through its one read and one write port in
// ST_SWEEP, before ST_READ. The result register lets the next request
// in while a result still waits on m_tready.
module led_marquee_scroller
    import lms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [SPEED_W-1:0]  cfg_wdata,     // scroll_speed
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,       // [5:0] column_index
    input  logic [REQ_W-1:0]    s_tuser,       // [2:0] req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata        // [7:0] column_data, [8] column_carry,
                                               // [10:9] scroll_mode, [11] shifted
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SWEEP = 4'b0010,
        ST_READ  = 4'b0100,
        ST_WAIT  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    mode_t                mode_reg, mode_next;
    logic [DELAY_W-1:0]   delay_reg, delay_next;
    logic [ADDR_W-1:0]    base_reg, base_next;
    logic [SPEED_W-1:0]   speed_reg;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 shifted_reg, shifted_next;
    logic [ADDR_W:0]      cnt_reg, cnt_next;
    logic                 wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0]    rd_addr_reg;
    logic [COLUMNS-1:0]   valid_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]     m_tdata_reg, m_tdata_next;

    logic [8:0]           mem [COLUMNS];
    logic [8:0]           rdata_reg;

    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 valid_clr;
    logic [8:0]           cur_entry;
    logic [8:0]           wr_data;
    logic [SPEED_W-1:0]   speed_sat;
    logic [DELAY_W-1:0]   speed_sub;
    logic [DELAY_W-1:0]   period;
    logic [DELAY_W-1:0]   tick_count;
    logic [ADDR_W-1:0]    base_inc;

    // {carry, data}; entries not yet written hold the glyph table
    assign cur_entry = valid_reg[rd_addr_reg] ? rdata_reg
                                              : {1'b0, glyph_at(rd_addr_reg)};
    assign wr_data   = {cur_entry[7], cur_entry[6:0], cur_entry[8]};

    assign speed_sat  = (speed_reg > SPEED_W'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX) : speed_reg;
    assign speed_sub  = DELAY_W'(speed_sat) * DELAY_W'(SPEED_STEP);
    assign period     = (speed_sub >= DELAY_W'(BASE_PERIOD)) ? DELAY_W'(1)
                                                             : DELAY_W'(BASE_PERIOD) - speed_sub;
    assign tick_count = delay_reg + DELAY_W'(1);
    assign base_inc   = (base_reg == ADDR_W'(COLUMNS - 1)) ? '0 : base_reg + ADDR_W'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        delay_next    = delay_reg;
        base_next     = base_reg;
        idx_next      = idx_reg;
        shifted_next  = shifted_reg;
        cnt_next      = cnt_reg;
        wr_pend_next  = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        valid_clr     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    idx_next     = s_tdata[IDX_W-1:0];
                    shifted_next = 1'b0;
                    cnt_next     = '0;
                    state_next   = ST_READ;
                    case (s_tuser)
                        REQ_TICK:
                        begin
                            if (mode_reg != MODE_STOP)
                            begin
                                if (tick_count >= period)
                                begin
                                    delay_next   = '0;
                                    shifted_next = 1'b1;
                                    if (mode_reg == MODE_HORIZ)
                                    begin
                                        base_next = base_inc;
                                    end
                                    else
                                    begin
                                        state_next = ST_SWEEP;
                                    end
                                end
                                else
                                begin
                                    delay_next = tick_count;
                                end
                            end
                        end
                        REQ_INIT:
                        begin
                            valid_clr  = 1'b1;
                            base_next  = '0;
                            mode_next  = MODE_STOP;
                            delay_next = '0;
                        end
                        REQ_HORIZ:
                        begin
                            mode_next    = MODE_HORIZ;
                            base_next    = base_inc;
                            delay_next   = '0;
                            shifted_next = 1'b1;
                        end
                        REQ_VERT:
                        begin
                            mode_next    = MODE_VERT;
                            delay_next   = '0;
                            shifted_next = 1'b1;
                            state_next   = ST_SWEEP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                if (cnt_reg < (ADDR_W + 1)'(COLUMNS))
                begin
                    rd_en        = 1'b1;
                    rd_addr      = cnt_reg[ADDR_W-1:0];
                    wr_pend_next = 1'b1;
                    cnt_next     = cnt_reg + (ADDR_W + 1)'(1);
                end
                else
                begin
                    // last write-back lands at this edge
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = phys_addr(idx_reg, base_reg);
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, shifted_reg, mode_reg, cur_entry[8],
                                     cur_entry[7:0]};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_STOP;
            delay_reg    <= '0;
            base_reg     <= '0;
            speed_reg    <= SPEED_W'(SPEED_RESET);
            shifted_reg  <= 1'b0;
            cnt_reg      <= '0;
            wr_pend_reg  <= 1'b0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            delay_reg    <= delay_next;
            base_reg     <= base_next;
            shifted_reg  <= shifted_next;
            cnt_reg      <= cnt_next;
            wr_pend_reg  <= wr_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                speed_reg <= cfg_wdata;
            end
            if (valid_clr)
            begin
                valid_reg <= '0;
            end
            else if (wr_pend_reg)
            begin
                valid_reg[rd_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
        if (rd_en)
        begin
            rd_addr_reg <= rd_addr;
        end
    end

    // column memory: write-back follows in the cycle after the read
    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            mem[rd_addr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/lms_checker.sv =====
// ----------------------------------------------------------------------------
// LED marquee scroller checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module lms_checker
    import lms_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [OUT_W-1:0]    m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while one is in progress");

    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[10:9] != 2'd3)
        else $error("bad scroll mode in result");

    a_shift_moving: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[11] |-> m_tdata[10:9] != MODE_STOP)
        else $error("shift reported while stopped");

endmodule

bind led_marquee_scroller lms_checker u_lms_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED marquee scroller testbench
// Drives requests over the input stream and checks every result transfer
// against a typed directed row's table value, else a cycle-free model of the
// frame buffer, its carries, the scroll mode and the tick counter. A directed
// table comes first, then a long tick run that reaches a timed shift, then
// mixed random traffic over several scroll speeds. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import lms_pkg::*;

    localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RSVD_5 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       carry;
        mode_t      mode;
        logic       shifted;
    } column_report_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [IDX_W-1:0] idx;
        logic             typed;
        column_report_t   value;
    } stim_row_t;

    localparam int DIRECTED_N = 22;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        '{REQ_READ,   6'd0,  1'b1, '{8'h00, 1'b0, MODE_STOP,  1'b0}},
        '{REQ_READ,   6'd1,  1'b1, '{8'h44, 1'b0, MODE_STOP,  1'b0}},
        '{REQ_READ,   6'd63, 1'b1, '{8'h00, 1'b0, MODE_STOP,  1'b0}},
        '{REQ_READ,   6'd17, 1'b1, '{8'h7E, 1'b0, MODE_STOP,  1'b0}},
        '{REQ_TICK,   6'd2,  1'b1, '{8'h6C, 1'b0, MODE_STOP,  1'b0}},
        '{REQ_RSVD_5, 6'd9,  1'b1, '{8'h58, 1'b0, MODE_STOP,  1'b0}},
        '{REQ_RSVD_7, 6'd42, 1'b1, '{8'h7C, 1'b0, MODE_STOP,  1'b0}},
        '{REQ_HORIZ,  6'd0,  1'b1, '{8'h44, 1'b0, MODE_HORIZ, 1'b1}},
        '{REQ_HORIZ,  6'd63, 1'b0, '0},
        '{REQ_READ,   6'd6,  1'b0, '0},
        '{REQ_VERT,   6'd8,  1'b0, '0},
        '{REQ_RSVD_6, 6'd31, 1'b0, '0},
        '{REQ_TICK,   6'd5,  1'b0, '0},
        '{REQ_VERT,   6'd63, 1'b0, '0},
        '{REQ_INIT,   6'd3,  1'b1, '{8'h38, 1'b0, MODE_STOP,  1'b0}},
        '{REQ_VERT,   6'd1,  1'b1, '{8'h88, 1'b0, MODE_VERT,  1'b1}},
        '{REQ_VERT,   6'd1,  1'b1, '{8'h10, 1'b1, MODE_VERT,  1'b1}},
        '{REQ_VERT,   6'd1,  1'b1, '{8'h21, 1'b0, MODE_VERT,  1'b1}},
        '{REQ_HORIZ,  6'd0,  1'b0, '0},
        '{REQ_READ,   6'd63, 1'b0, '0},
        '{REQ_READ,   6'd32, 1'b0, '0},
        '{REQ_INIT,   6'd62, 1'b1, '{8'h7C, 1'b0, MODE_STOP,  1'b0}}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [SPEED_W-1:0] cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;
    logic [REQ_W-1:0]   s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;

    // model state
    logic [7:0]         pix [COLUMNS];
    logic               carry_bits [COLUMNS];
    mode_t              mode_now;
    logic [DELAY_W-1:0] tick_cnt;
    logic [SPEED_W-1:0] speed_now;

    typedef struct packed {
        logic           typed;
        column_report_t value;
    } fixed_answer_t;

    column_report_t pending_reports [$];
    fixed_answer_t  fixed_answers [$];
    int             timed_shifts;
    int             err_cnt;
    bit             calm;
    bit             hold_req;

    led_marquee_scroller DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void load_glyph_frame();
        for (int i = 0; i < COLUMNS; i++)
        begin
            pix[i]        = GLYPH_ROM[i % 64];
            carry_bits[i] = 1'b0;
        end
    endfunction

    function automatic void shift_frame();
        logic [7:0] first_pix;
        logic       first_carry;
        logic       out_bit;
        if (mode_now == MODE_HORIZ)
        begin
            first_pix   = pix[0];
            first_carry = carry_bits[0];
            for (int i = 0; i < COLUMNS - 1; i++)
            begin
                pix[i]        = pix[i + 1];
                carry_bits[i] = carry_bits[i + 1];
            end
            pix[COLUMNS - 1]        = first_pix;
            carry_bits[COLUMNS - 1] = first_carry;
        end
        else if (mode_now == MODE_VERT)
        begin
            for (int i = 0; i < COLUMNS; i++)
            begin
                out_bit       = pix[i][7];
                pix[i]        = {pix[i][6:0], carry_bits[i]};
                carry_bits[i] = out_bit;
            end
        end
    endfunction

    function automatic column_report_t advance_marquee(input logic [REQ_W-1:0] req,
                                                       input logic [IDX_W-1:0] idx);
        column_report_t r;
        int col;
        int spd;
        int period;
        logic moved;
        col   = int'(idx) % COLUMNS;
        moved = 1'b0;
        case (req)
            REQ_TICK:
            begin
                if (mode_now != MODE_STOP)
                begin
                    spd      = (speed_now > SPEED_MAX) ? SPEED_MAX : int'(speed_now);
                    period   = (spd * SPEED_STEP >= BASE_PERIOD) ? 1
                                                                 : BASE_PERIOD - spd * SPEED_STEP;
                    tick_cnt = tick_cnt + 1'b1;
                    if (int'(tick_cnt) >= period)
                    begin
                        shift_frame();
                        tick_cnt = '0;
                        moved    = 1'b1;
                        timed_shifts++;
                    end
                end
            end
            REQ_INIT:
            begin
                load_glyph_frame();
                mode_now = MODE_STOP;
                tick_cnt = '0;
            end
            REQ_HORIZ, REQ_VERT:
            begin
                mode_now = (req == REQ_HORIZ) ? MODE_HORIZ : MODE_VERT;
                shift_frame();
                tick_cnt = '0;
                moved    = 1'b1;
            end
            default: ;
        endcase
        r.data    = pix[col];
        r.carry   = carry_bits[col];
        r.mode    = mode_now;
        r.shifted = moved;
        return r;
    endfunction

    // result check, then model update for the transfer taken at this edge
    always @(posedge clk)
    begin
        column_report_t want;
        fixed_answer_t  note;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("result with nothing pending, tdata %h", m_tdata);
                    err_cnt++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (m_tdata[7:0] !== want.data)
                    begin
                        $error("column_data: expected %h, got %h", want.data, m_tdata[7:0]);
                        err_cnt++;
                    end
                    if (m_tdata[8] !== want.carry)
                    begin
                        $error("column_carry: expected %b, got %b", want.carry, m_tdata[8]);
                        err_cnt++;
                    end
                    if (m_tdata[10:9] !== want.mode)
                    begin
                        $error("scroll_mode: expected %0d, got %0d", want.mode, m_tdata[10:9]);
                        err_cnt++;
                    end
                    if (m_tdata[11] !== want.shifted)
                    begin
                        $error("shifted: expected %b, got %b", want.shifted, m_tdata[11]);
                        err_cnt++;
                    end
                end
            end
            if (cfg_we)
                speed_now = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                note = fixed_answers.pop_front();
                want = advance_marquee(s_tuser, s_tdata[IDX_W-1:0]);
                pending_reports.push_back(note.typed ? note.value : want);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [IDX_W-1:0] rand_col();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 6'd63 : 6'd0;
        return IDX_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [REQ_W-1:0] rand_rsvd();
        return REQ_W'($urandom_range(REQ_RSVD_5, REQ_RSVD_7));
    endfunction

    // receiver: random stalls, plus one long hold on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < 25)
            begin
                m_tready <= 1'b0;
                repeat (pick_gap()) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_req(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                            input logic typed, input column_report_t value);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        fixed_answers.push_back(fixed_answer_t'{typed, value});
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(idx);
        s_tuser  <= req;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_reports.size() != 0);
    endtask

    task automatic set_speed(input logic [SPEED_W-1:0] v);
        wait_drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // start, then mostly ticks until one timed shift has happened and a bit beyond
    task automatic run_timed_shift(input logic [REQ_W-1:0] start_req);
        int goal;
        int tail;
        int n;
        int r;
        logic [REQ_W-1:0] req;
        goal = timed_shifts + 1;
        tail = 0;
        n    = 0;
        send_req(start_req, rand_col(), 1'b0, '0);
        while (tail < 25)
        begin
            r = $urandom_range(0, 99);
            if (r < 94)
                req = REQ_TICK;
            else if (r < 98)
                req = REQ_READ;
            else
                req = rand_rsvd();
            send_req(req, rand_col(), 1'b0, '0);
            n++;
            if (n == 60)
                hold_req = 1'b1;
            if (timed_shifts >= goal)
                tail++;
        end
    endtask

    initial
    begin
        int r;
        logic [REQ_W-1:0] req;
        logic [SPEED_W-1:0] spd;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        err_cnt      = 0;
        timed_shifts = 0;
        load_glyph_frame();
        mode_now  = MODE_STOP;
        tick_cnt  = '0;
        speed_now = SPEED_W'(SPEED_RESET);
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
            send_req(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].idx,
                     DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].value);

        set_speed(7'd127);
        run_timed_shift(REQ_VERT);

        for (int seg = 0; seg < 12; seg++)
        begin
            case ($urandom_range(0, 4))
                0: spd = 7'd1;
                1: spd = 7'd99;
                2: spd = 7'd100;
                default: spd = SPEED_W'($urandom_range(0, 127));
            endcase
            set_speed((seg == 0) ? 7'd0 : spd);
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(40, 60))
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                    req = REQ_TICK;
                else if (r < 55)
                    req = REQ_READ;
                else if (r < 63)
                    req = REQ_INIT;
                else if (r < 76)
                    req = REQ_HORIZ;
                else if (r < 89)
                    req = REQ_VERT;
                else
                    req = rand_rsvd();
                send_req(req, rand_col(), 1'b0, '0);
            end
        end

        wait_drain();
        repeat (100) @(negedge clk);
        if (err_cnt == 0 && pending_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== led_marquee_scroller.f =====
rtl/core/lms_pkg.sv
rtl/core/led_marquee_scroller.sv
rtl/core/lms_checker.sv
verif/testbench.sv
